// ----- src/sacr_pkg.sv -----
`default_nettype none
package sacr_pkg;

   localparam int DEF_NUM_SETS   = 64;
   localparam int DEF_NUM_WAYS   = 8;
   localparam int DEF_STAMP_BITS = 32;

   localparam int ADDR_BITS = 64;
   localparam int LINE_BITS = 60;
   localparam int TS_BITS   = 32;
   localparam int AGE_BITS  = 2;
   localparam int OFF_BITS  = 4;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 4;

   localparam logic [OFF_BITS-1:0] OFF_MIN   = 4'd4;
   localparam logic [OFF_BITS-1:0] OFF_MAX   = 4'd12;
   localparam logic [OFF_BITS-1:0] OFF_RESET = 4'd6;
   localparam logic [AGE_BITS-1:0] AGE_MAX   = 2'd3;

   localparam logic MODE_LRU  = 1'b0;
   localparam logic MODE_QUAD = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET = 1'd1;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_PROBE  = 2'd1,
      OP_FILL   = 2'd2,
      OP_INVAL  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

// ----- src/sacr_ram.sv -----
`default_nettype none
module sacr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- src/sacr_victim.sv -----
`default_nettype none
module sacr_victim #(
   parameter int NUM_WAYS = 8,
   parameter int KEY_BITS = 34
) (
   input  wire logic [NUM_WAYS-1:0][KEY_BITS-1:0]             keys,
   output logic      [(NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1)-1:0] way
);

   localparam int WAY_BITS = $clog2(NUM_WAYS);
   localparam int WAY_IW   = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int LEAVES   = 1 << WAY_BITS;

   // heap layout: node i has children 2i and 2i+1, leaves start at LEAVES
   logic [KEY_BITS-1:0] nkey [1:2*LEAVES-1];
   logic [WAY_IW-1:0]   nidx [1:2*LEAVES-1];

   for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
      if (l < NUM_WAYS) begin : g_real
         assign nkey[LEAVES+l] = keys[l];
      end else begin : g_pad
         assign nkey[LEAVES+l] = '1;
      end
      assign nidx[LEAVES+l] = WAY_IW'(l);
   end

   // left wins on a tie, so the lowest way wins among equal keys
   for (genvar n = 1; n < LEAVES; n++) begin : g_node
      assign nkey[n] = (nkey[2*n+1] < nkey[2*n]) ? nkey[2*n+1] : nkey[2*n];
      assign nidx[n] = (nkey[2*n+1] < nkey[2*n]) ? nidx[2*n+1] : nidx[2*n];
   end

   assign way = nidx[1];

endmodule
`default_nettype wire

// ----- src/set_associative_cache_replacement.sv -----
`default_nettype none
// Channel   Handshake                Payload
// req       req_valid / req_stall    opcode, address, timestamp, prefetch_flag
// rsp       rsp_valid / rsp_stall    hit, useful_pf, evicted_valid,
//                                    evicted_line_address, evicted_prefetched
// csr       csr_write_enable         csr_index, csr_write_data
//
// Each request is a read-modify-write of one set row: the accept edge reads the
// set's row from the tag and state memories, and the execute state compares all
// ways, picks a victim and writes the row back. After reset a clearing pass over
// all NUM_SETS rows resets the state memory; no request is taken during it. The
// result waits in an output register; a stalled result holds the write-back of
// the next request.
module set_associative_cache_replacement #(
   parameter int NUM_SETS   = sacr_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS   = sacr_pkg::DEF_NUM_WAYS,
   parameter int STAMP_BITS = sacr_pkg::DEF_STAMP_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic [sacr_pkg::ADDR_BITS-1:0]      req_address,
   input  wire logic [sacr_pkg::TS_BITS-1:0]        req_timestamp,
   input  wire logic                                req_prefetch_flag,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic                                     rsp_useful_pf,
   output logic                                     rsp_evicted_valid,
   output logic      [sacr_pkg::LINE_BITS-1:0]      rsp_evicted_line_address,
   output logic                                     rsp_evicted_prefetched,
   input  wire logic                                csr_write_enable,
   input  wire logic [sacr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [sacr_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int SET_IW    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_BITS  = $clog2(NUM_WAYS);
   localparam int WAY_IW    = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int TAG_BITS  = sacr_pkg::LINE_BITS - SET_BITS;
   localparam int DATA_W    = TAG_BITS + STAMP_BITS;
   localparam int META_W    = 2 + sacr_pkg::AGE_BITS;
   localparam int KEY_BITS  = sacr_pkg::AGE_BITS + STAMP_BITS;
   localparam logic [SET_IW-1:0] SET_MASK = SET_IW'(NUM_SETS - 1);

   typedef struct packed {
      logic                          valid;
      logic                          pf;
      logic [sacr_pkg::AGE_BITS-1:0] age;
   } meta_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]   tag;
      logic [STAMP_BITS-1:0] stamp;
   } data_type;

   // configuration
   logic                          mode_ff;
   logic [sacr_pkg::OFF_BITS-1:0] offs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sacr_pkg::MODE_LRU;
         offs_ff <= sacr_pkg::OFF_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sacr_pkg::CSR_MODE:   mode_ff <= csr_write_data[0];
            sacr_pkg::CSR_OFFSET: offs_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   sacr_pkg::state_type state_ff, state_in;
   logic [SET_IW-1:0]   clr_ff, clr_in;
   logic                accept;
   logic                exec_go;

   // request decode at the accept edge
   logic [sacr_pkg::OFF_BITS-1:0]  shift;
   logic [sacr_pkg::LINE_BITS-1:0] laddr;
   logic [SET_IW-1:0]              req_set;

   always_comb begin
      if (offs_ff < sacr_pkg::OFF_MIN) begin
         shift = sacr_pkg::OFF_MIN;
      end else if (offs_ff > sacr_pkg::OFF_MAX) begin
         shift = sacr_pkg::OFF_MAX;
      end else begin
         shift = offs_ff;
      end
      laddr   = sacr_pkg::LINE_BITS'(req_address >> shift);
      req_set = laddr[SET_IW-1:0] & SET_MASK;
   end

   sacr_pkg::op_type      op_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [SET_IW-1:0]     set_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  pf_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= sacr_pkg::op_type'(req_opcode);
         tag_ff   <= laddr[sacr_pkg::LINE_BITS-1:SET_BITS];
         set_ff   <= req_set;
         stamp_ff <= STAMP_BITS'(req_timestamp);
         pf_ff    <= req_prefetch_flag;
      end
   end

   // memories
   data_type [NUM_WAYS-1:0] data_rd, data_wr;
   meta_type [NUM_WAYS-1:0] meta_rd, meta_wr, meta_wdata;
   logic                    meta_we;
   logic [SET_IW-1:0]       meta_waddr;

   sacr_ram #(.WIDTH(NUM_WAYS * DATA_W), .DEPTH(NUM_SETS)) u_data_ram (
      .clock   (clock),
      .wr_en   (exec_go),
      .wr_addr (set_ff),
      .wr_data (data_wr),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (data_rd)
   );

   sacr_ram #(.WIDTH(NUM_WAYS * META_W), .DEPTH(NUM_SETS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (meta_rd)
   );

   // victim pick over the row as read, before any aging
   logic [NUM_WAYS-1:0][KEY_BITS-1:0] keys;
   logic [WAY_IW-1:0]                 victim;

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         keys[w] = {(mode_ff == sacr_pkg::MODE_QUAD) ? meta_rd[w].age
                                                     : {sacr_pkg::AGE_BITS{1'b0}},
                    data_rd[w].stamp};
      end
   end

   sacr_victim #(.NUM_WAYS(NUM_WAYS), .KEY_BITS(KEY_BITS)) u_victim (
      .keys (keys),
      .way  (victim)
   );

   // compare and update
   logic              found, free_any, age_en, evict;
   logic [WAY_IW-1:0] found_w, free_w, target;
   logic              useful;

   always_comb begin
      found    = 1'b0;
      found_w  = '0;
      free_any = 1'b0;
      free_w   = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!found && meta_rd[w].valid && data_rd[w].tag == tag_ff) begin
            found   = 1'b1;
            found_w = WAY_IW'(w);
         end
         if (!free_any && !meta_rd[w].valid) begin
            free_any = 1'b1;
            free_w   = WAY_IW'(w);
         end
      end

      evict  = (op_ff == sacr_pkg::OP_FILL) && !found && !free_any;
      target = found ? found_w : (free_any ? free_w : victim);
      useful = (op_ff == sacr_pkg::OP_LOOKUP) && found && !pf_ff && meta_rd[found_w].pf;
      age_en = (mode_ff == sacr_pkg::MODE_QUAD) &&
               ((op_ff == sacr_pkg::OP_LOOKUP && found) || op_ff == sacr_pkg::OP_FILL);

      meta_wr = meta_rd;
      data_wr = data_rd;
      // age the other valid lines (all of them on a fill that misses)
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (age_en && meta_rd[w].valid && meta_rd[w].age != '0 &&
             !(found && WAY_IW'(w) == found_w)) begin
            meta_wr[w].age = meta_rd[w].age - 2'd1;
         end
      end

      case (op_ff)
         sacr_pkg::OP_LOOKUP: begin
            if (found) begin
               data_wr[found_w].stamp = stamp_ff;
               meta_wr[found_w].age   = sacr_pkg::AGE_MAX;
               meta_wr[found_w].pf    = 1'b0;
            end
         end
         sacr_pkg::OP_FILL: begin
            data_wr[target].stamp = stamp_ff;
            data_wr[target].tag   = found ? data_rd[target].tag : tag_ff;
            meta_wr[target].age   = sacr_pkg::AGE_MAX;
            meta_wr[target].valid = 1'b1;
            meta_wr[target].pf    = found ? (meta_rd[target].pf | pf_ff) : pf_ff;
         end
         sacr_pkg::OP_INVAL: begin
            if (found) begin
               meta_wr[found_w].valid = 1'b0;
               meta_wr[found_w].pf    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // state machine: clearing pass, then one request at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacr_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      accept     = 1'b0;
      exec_go    = 1'b0;
      req_stall  = 1'b1;
      meta_we    = 1'b0;
      meta_waddr = set_ff;
      meta_wdata = meta_wr;
      case (state_ff)
         sacr_pkg::ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            for (int w = 0; w < NUM_WAYS; w++) begin
               meta_wdata[w] = '{valid: 1'b0, pf: 1'b0, age: sacr_pkg::AGE_MAX};
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_MASK) begin
               state_in = sacr_pkg::ST_IDLE;
            end
         end
         sacr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            if (req_valid) begin
               state_in = sacr_pkg::ST_EXEC;
            end
         end
         sacr_pkg::ST_EXEC: begin
            // hold while the previous result is still waiting
            exec_go  = !rsp_valid || !rsp_stall;
            meta_we  = exec_go;
            if (exec_go) begin
               state_in = sacr_pkg::ST_IDLE;
            end
         end
         default: state_in = sacr_pkg::ST_IDLE;
      endcase
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_hit                  <= found;
         rsp_useful_pf            <= useful;
         rsp_evicted_valid        <= evict;
         rsp_evicted_prefetched   <= evict && meta_rd[victim].pf;
         rsp_evicted_line_address <= evict ?
            ((sacr_pkg::LINE_BITS'(data_rd[victim].tag) << SET_BITS) |
             sacr_pkg::LINE_BITS'(set_ff)) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- src/sacr_checker.sv -----
`default_nettype none
module sacr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic                               rsp_hit,
   input wire logic                               rsp_useful_pf,
   input wire logic                               rsp_evicted_valid,
   input wire logic [sacr_pkg::LINE_BITS-1:0]     rsp_evicted_line_address,
   input wire logic                               rsp_evicted_prefetched
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while one is in flight");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_useful_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_useful_pf |-> rsp_hit && !rsp_evicted_valid)
      else $error("useful prefetch without a hit");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |->
         rsp_evicted_line_address == '0 && !rsp_evicted_prefetched)
      else $error("eviction fields set without an eviction");

endmodule

bind set_associative_cache_replacement sacr_checker u_sacr_checker (.*);
`default_nettype wire
